// ===== rtl/core/tba_pkg.sv =====
// ---------------------------------------------------------------------------
// tba_pkg
// Shared payload types, codes and controller/datapath interface structs for
// the trace record time bucket aggregator.
// ---------------------------------------------------------------------------
package tba_pkg;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] kernel_id;
      logic [9:0]  sm_id;
      logic [63:0] time_start;
      logic [63:0] time_end;
      logic [63:0] drop_amount;
      logic [7:0]  read_row;
      logic [9:0]  read_column;
   } req_type;

   typedef struct packed {
      logic [63:0] read_value;
      logic [2:0]  status;
   } rsp_type;

   localparam logic [2:0] ACT_REGISTER = 3'd0;
   localparam logic [2:0] ACT_RECORD   = 3'd1;
   localparam logic [2:0] ACT_DROP     = 3'd2;
   localparam logic [2:0] ACT_RD_HEAT  = 3'd3;
   localparam logic [2:0] ACT_RD_KBKT  = 3'd4;
   localparam logic [2:0] ACT_RD_KTOT  = 3'd5;
   localparam logic [2:0] ACT_RD_KID   = 3'd6;
   localparam logic [2:0] ACT_RD_CNT   = 3'd7;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_SM_RANGE = 3'd2;
   localparam logic [2:0] ST_UNKNOWN  = 3'd3;
   localparam logic [2:0] ST_INDEX    = 3'd4;

   localparam logic [9:0] CNT_KERNELS = 10'd0;
   localparam logic [9:0] CNT_RECORDS = 10'd1;
   localparam logic [9:0] CNT_DROPS   = 10'd2;

   localparam logic [7:0] CFG_START_TIME   = 8'd0;
   localparam logic [7:0] CFG_BUCKET_WIDTH = 8'd1;

   localparam logic [31:0] MIX_C1 = 32'h85ebca6b;
   localparam logic [31:0] MIX_C2 = 32'hc2b2ae35;

   typedef struct packed {
      logic capture;
      logic clr_step;
      logic mix1;
      logic mix2;
      logic probe_start;
      logic slot_rd;
      logic kid_rd;
      logic probe_next;
      logic insert;
      logic row_hit;
      logic row_miss;
      logic div_start;
      logic div_step;
      logic rmw_rd;
      logic rmw_wr;
      logic rd_issue;
      logic drop_add;
      logic rsp_load;
   } tba_cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       idx_bad;
      logic       div_last;
      logic       slot_empty;
      logic       kid_match;
      logic       probe_last;
      logic       count_full;
      logic       rsp_free;
      logic       clr_last;
   } tba_stat_type;

endpackage

// ===== rtl/core/tba_ram.sv =====
// ---------------------------------------------------------------------------
// tba_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module tba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic                                        re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/core/tba_ctrl.sv =====
// ---------------------------------------------------------------------------
// tba_ctrl
// Sequencer: clearing pass, dispatch, bucket division, hash probe walk,
// read-modify-write of the stores and result hand-off.
// ---------------------------------------------------------------------------
module tba_ctrl
   import tba_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  tba_stat_type stat,
   output tba_cmd_type  cmd
);
   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_DISPATCH = 4'd2;
   localparam logic [3:0] S_DIV      = 4'd3;
   localparam logic [3:0] S_MIX2     = 4'd4;
   localparam logic [3:0] S_MIX3     = 4'd5;
   localparam logic [3:0] S_SLOT     = 4'd6;
   localparam logic [3:0] S_CHK      = 4'd7;
   localparam logic [3:0] S_CMP      = 4'd8;
   localparam logic [3:0] S_RMWRD    = 4'd9;
   localparam logic [3:0] S_RMWWR    = 4'd10;
   localparam logic [3:0] S_RDWAIT   = 4'd11;
   localparam logic [3:0] S_DONE     = 4'd12;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.action)
               ACT_REGISTER: begin
                  cmd.mix1 = 1'b1;
                  state_in = S_MIX2;
               end
               ACT_RECORD: begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV;
               end
               ACT_DROP: begin
                  cmd.drop_add = 1'b1;
                  state_in     = S_DONE;
               end
               ACT_RD_CNT: state_in = S_DONE;
               default: begin
                  if (stat.idx_bad) begin
                     state_in = S_DONE;
                  end else begin
                     cmd.rd_issue = 1'b1;
                     state_in     = S_RDWAIT;
                  end
               end
            endcase
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               cmd.mix1 = 1'b1;
               state_in = S_MIX2;
            end
         end
         S_MIX2: begin
            cmd.mix2 = 1'b1;
            state_in = S_MIX3;
         end
         S_MIX3: begin
            cmd.probe_start = 1'b1;
            state_in        = S_SLOT;
         end
         S_SLOT: begin
            cmd.slot_rd = 1'b1;
            state_in    = S_CHK;
         end
         S_CHK: begin
            if (stat.slot_empty) begin
               if (stat.action == ACT_REGISTER) begin
                  if (stat.count_full) cmd.row_miss = 1'b1;
                  else cmd.insert = 1'b1;
                  state_in = S_DONE;
               end else begin
                  cmd.row_miss = 1'b1;
                  state_in     = S_RMWRD;
               end
            end else begin
               cmd.kid_rd = 1'b1;
               state_in   = S_CMP;
            end
         end
         S_CMP: begin
            if (stat.kid_match || stat.probe_last) begin
               if (stat.kid_match) cmd.row_hit = 1'b1;
               else cmd.row_miss = 1'b1;
               state_in = (stat.action == ACT_REGISTER) ? S_DONE : S_RMWRD;
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = S_SLOT;
            end
         end
         S_RMWRD: begin
            cmd.rmw_rd = 1'b1;
            state_in   = S_RMWWR;
         end
         S_RMWWR: begin
            cmd.rmw_wr = 1'b1;
            state_in   = S_DONE;
         end
         S_RDWAIT: state_in = S_DONE;
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else state_ff <= state_in;
   end

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DISPATCH))
      else $error("accepted beat did not move to dispatch");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> stat.rsp_free)
      else $error("result loaded over an untaken result");
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clr_step, cmd.insert, cmd.rmw_wr}))
      else $error("two store writers in one cycle");
endmodule

// ===== rtl/core/tba_dpath.sv =====
// ---------------------------------------------------------------------------
// tba_dpath
// Datapath: configuration registers, hash mixer, probe registers, bucket
// divider, the store RAMs, counters and the result register.
// ---------------------------------------------------------------------------
module tba_dpath
   import tba_pkg::*;
#(
   parameter int SM_COUNT     = 128,
   parameter int BUCKET_COUNT = 256,
   parameter int KERNEL_LIMIT = 64,
   parameter int HASH_BITS    = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  req_type      req_data,
   input  logic         csr_valid,
   input  logic [7:0]   csr_index,
   input  logic [63:0]  csr_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data,
   input  tba_cmd_type  cmd,
   output tba_stat_type stat
);
   localparam int ROWS       = KERNEL_LIMIT + 1;
   localparam int SLOTS      = 1 << HASH_BITS;
   localparam int ROW_W      = $clog2(ROWS);
   localparam int BKT_W      = $clog2(BUCKET_COUNT);
   localparam int HEAT_DEPTH = SM_COUNT * BUCKET_COUNT;
   localparam int HEAT_AW    = $clog2(HEAT_DEPTH);
   localparam int KBT_DEPTH  = ROWS * BUCKET_COUNT;
   localparam int KBT_AW     = $clog2(KBT_DEPTH);
   localparam int KID_AW     = (KERNEL_LIMIT > 1) ? $clog2(KERNEL_LIMIT) : 1;
   localparam int CLR_A      = (HEAT_DEPTH > KBT_DEPTH) ? HEAT_DEPTH : KBT_DEPTH;
   localparam int CLR_DEPTH  = (CLR_A > SLOTS) ? CLR_A : SLOTS;
   localparam int CLR_W      = $clog2(CLR_DEPTH + 1);
   localparam int DCNT_W     = $clog2(BKT_W + 1);

   req_type               req_ff;
   logic [63:0]           start_ff, width_ff;
   logic [CLR_W-1:0]      clr_ff;
   logic [31:0]           p1_ff, p2_ff;
   logic [HASH_BITS-1:0]  pos_ff, probe_n_ff;
   logic [ROW_W-1:0]      v_ff, row_ff, count_ff;
   logic                  fail_ff;
   logic [63:0]           rem_ff;
   logic [63+BKT_W:0]     dvs_ff;
   logic [BKT_W:0]        q_ff;
   logic [DCNT_W-1:0]     dcnt_ff;
   logic [63:0]           rec_ff, drop_ff;
   rsp_type               rsp_ff;
   logic                  rsp_valid_ff;

   logic [31:0]           m0, m1, hash;
   logic [BKT_W-1:0]      bkt;
   logic [63:0]           dur, w_eff, diff;
   logic                  div_ge, clearing;
   rsp_type               rsp_in;

   logic [ROW_W-1:0]      slot_q;
   logic [31:0]           kid_q, heat_q;
   logic [63:0]           kbt_q, ktot_q;

   logic                  slot_we, kid_we, heat_we, kbt_we, ktot_we;
   logic [HASH_BITS-1:0]  slot_wa;
   logic [ROW_W-1:0]      slot_wd;
   logic [KID_AW-1:0]     kid_ra;
   logic [HEAT_AW-1:0]    heat_wa, heat_ra, heat_rec, heat_rd;
   logic [KBT_AW-1:0]     kbt_wa, kbt_ra, kbt_rec, kbt_rd;
   logic [ROW_W-1:0]      ktot_wa, ktot_ra;
   logic [31:0]           heat_wd;
   logic [63:0]           kbt_wd, ktot_wd;
   logic                  sm_ok;

   // Hash finaliser, one multiply per stage.
   assign m0   = req_ff.kernel_id ^ (req_ff.kernel_id >> 16);
   assign m1   = p1_ff ^ (p1_ff >> 13);
   assign hash = p2_ff ^ (p2_ff >> 16);

   assign w_eff  = (width_ff == 64'd0) ? 64'd1 : width_ff;
   assign diff   = (req_ff.time_start < start_ff) ? 64'd0 : req_ff.time_start - start_ff;
   assign dur    = (req_ff.time_end >= req_ff.time_start) ?
                   req_ff.time_end - req_ff.time_start : 64'd0;
   assign div_ge = {{BKT_W{1'b0}}, rem_ff} >= dvs_ff;
   assign bkt    = (q_ff >= (BKT_W+1)'(BUCKET_COUNT)) ?
                   BKT_W'(BUCKET_COUNT - 1) : q_ff[BKT_W-1:0];
   assign sm_ok  = 32'(req_ff.sm_id) < SM_COUNT;
   assign clearing = cmd.clr_step;

   assign heat_rec = HEAT_AW'(32'(req_ff.sm_id) * BUCKET_COUNT + 32'(bkt));
   assign heat_rd  = HEAT_AW'(32'(req_ff.read_row) * BUCKET_COUNT + 32'(req_ff.read_column));
   assign kbt_rec  = KBT_AW'(32'(row_ff) * BUCKET_COUNT + 32'(bkt));
   assign kbt_rd   = KBT_AW'(32'(req_ff.read_row) * BUCKET_COUNT + 32'(req_ff.read_column));

   assign heat_ra = cmd.rd_issue ? heat_rd : heat_rec;
   assign kbt_ra  = cmd.rd_issue ? kbt_rd : kbt_rec;
   assign ktot_ra = cmd.rd_issue ? ROW_W'(req_ff.read_row) : row_ff;
   assign kid_ra  = cmd.rd_issue ? KID_AW'(req_ff.read_row) : KID_AW'(slot_q - ROW_W'(1));

   always_comb begin
      slot_we = 1'b0;
      slot_wa = pos_ff;
      slot_wd = count_ff + ROW_W'(1);
      kid_we  = cmd.insert;
      heat_we = 1'b0;
      heat_wa = heat_rec;
      heat_wd = heat_q + 32'd1;
      kbt_we  = 1'b0;
      kbt_wa  = kbt_rec;
      kbt_wd  = kbt_q + dur;
      ktot_we = 1'b0;
      ktot_wa = row_ff;
      ktot_wd = ktot_q + dur;
      if (clearing) begin
         slot_we = 32'(clr_ff) < SLOTS;
         slot_wa = HASH_BITS'(clr_ff);
         slot_wd = '0;
         heat_we = 32'(clr_ff) < HEAT_DEPTH;
         heat_wa = HEAT_AW'(clr_ff);
         heat_wd = '0;
         kbt_we  = 32'(clr_ff) < KBT_DEPTH;
         kbt_wa  = KBT_AW'(clr_ff);
         kbt_wd  = '0;
         ktot_we = 32'(clr_ff) < ROWS;
         ktot_wa = ROW_W'(clr_ff);
         ktot_wd = '0;
      end else begin
         slot_we = cmd.insert;
         heat_we = cmd.rmw_wr && sm_ok;
         kbt_we  = cmd.rmw_wr;
         ktot_we = cmd.rmw_wr;
      end
   end

   tba_ram #(.WIDTH(ROW_W), .DEPTH(SLOTS)) u_slots (
      .clock(clock), .we(slot_we), .waddr(slot_wa), .wdata(slot_wd),
      .re(cmd.slot_rd), .raddr(pos_ff), .rdata(slot_q));

   tba_ram #(.WIDTH(32), .DEPTH(KERNEL_LIMIT)) u_kids (
      .clock(clock), .we(kid_we), .waddr(KID_AW'(count_ff)), .wdata(req_ff.kernel_id),
      .re(cmd.kid_rd || cmd.rd_issue), .raddr(kid_ra), .rdata(kid_q));

   tba_ram #(.WIDTH(32), .DEPTH(HEAT_DEPTH)) u_heat (
      .clock(clock), .we(heat_we), .waddr(heat_wa), .wdata(heat_wd),
      .re(cmd.rmw_rd || cmd.rd_issue), .raddr(heat_ra), .rdata(heat_q));

   tba_ram #(.WIDTH(64), .DEPTH(KBT_DEPTH)) u_kbt (
      .clock(clock), .we(kbt_we), .waddr(kbt_wa), .wdata(kbt_wd),
      .re(cmd.rmw_rd || cmd.rd_issue), .raddr(kbt_ra), .rdata(kbt_q));

   tba_ram #(.WIDTH(64), .DEPTH(ROWS)) u_ktot (
      .clock(clock), .we(ktot_we), .waddr(ktot_wa), .wdata(ktot_wd),
      .re(cmd.rmw_rd || cmd.rd_issue), .raddr(ktot_ra), .rdata(ktot_q));

   // Status towards the controller.
   always_comb begin
      stat            = '0;
      stat.action     = req_ff.action;
      stat.div_last   = dcnt_ff == '0;
      stat.slot_empty = slot_q == '0;
      stat.kid_match  = (32'(v_ff) <= KERNEL_LIMIT) && (kid_q == req_ff.kernel_id);
      stat.probe_last = probe_n_ff == HASH_BITS'(SLOTS - 1);
      stat.count_full = 32'(count_ff) >= KERNEL_LIMIT;
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
      stat.clr_last   = 32'(clr_ff) == CLR_DEPTH - 1;
      case (req_ff.action)
         ACT_RD_HEAT: stat.idx_bad = !((32'(req_ff.read_row) < SM_COUNT) &&
                                       (32'(req_ff.read_column) < BUCKET_COUNT));
         ACT_RD_KBKT: stat.idx_bad = !((32'(req_ff.read_row) <= KERNEL_LIMIT) &&
                                       (32'(req_ff.read_column) < BUCKET_COUNT));
         ACT_RD_KTOT: stat.idx_bad = !(32'(req_ff.read_row) <= KERNEL_LIMIT);
         ACT_RD_KID:  stat.idx_bad = !((32'(req_ff.read_row) < 32'(count_ff)) &&
                                       (32'(req_ff.read_row) < KERNEL_LIMIT));
         default:     stat.idx_bad = 1'b0;
      endcase
   end

   // Result formation.
   always_comb begin
      rsp_in.read_value = 64'd0;
      rsp_in.status     = ST_OK;
      case (req_ff.action)
         ACT_REGISTER: begin
            if (fail_ff) rsp_in.status = ST_FULL;
            else rsp_in.read_value = 64'(row_ff);
         end
         ACT_RECORD: begin
            rsp_in.read_value = 64'(row_ff);
            if (!sm_ok) rsp_in.status = ST_SM_RANGE;
            else if (fail_ff) rsp_in.status = ST_UNKNOWN;
         end
         ACT_DROP: rsp_in.read_value = drop_ff;
         ACT_RD_CNT: begin
            case (req_ff.read_column)
               CNT_KERNELS: rsp_in.read_value = 64'(count_ff);
               CNT_RECORDS: rsp_in.read_value = rec_ff;
               CNT_DROPS:   rsp_in.read_value = drop_ff;
               default:     rsp_in.status = ST_INDEX;
            endcase
         end
         default: begin
            if (stat.idx_bad) begin
               rsp_in.status = ST_INDEX;
            end else begin
               case (req_ff.action)
                  ACT_RD_HEAT: rsp_in.read_value = 64'(heat_q);
                  ACT_RD_KBKT: rsp_in.read_value = kbt_q;
                  ACT_RD_KTOT: rsp_in.read_value = ktot_q;
                  default:     rsp_in.read_value = 64'(kid_q);
               endcase
            end
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= 64'd0;
         width_ff     <= 64'd1;
         clr_ff       <= '0;
         count_ff     <= '0;
         rec_ff       <= 64'd0;
         drop_ff      <= 64'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_index == CFG_START_TIME) start_ff <= csr_data;
         if (csr_valid && csr_index == CFG_BUCKET_WIDTH) width_ff <= csr_data;
         if (cmd.clr_step) clr_ff <= clr_ff + CLR_W'(1);
         if (cmd.insert) count_ff <= count_ff + ROW_W'(1);
         if (cmd.rmw_wr) rec_ff <= rec_ff + 64'd1;
         if (cmd.drop_add) drop_ff <= drop_ff + req_ff.drop_amount;
         if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff  <= req_data;
         fail_ff <= 1'b0;
      end
      if (cmd.mix1) p1_ff <= m0 * MIX_C1;
      if (cmd.mix2) p2_ff <= m1 * MIX_C2;
      if (cmd.probe_start) begin
         pos_ff     <= hash[HASH_BITS-1:0];
         probe_n_ff <= '0;
      end
      if (cmd.probe_next) begin
         pos_ff     <= pos_ff + HASH_BITS'(1);
         probe_n_ff <= probe_n_ff + HASH_BITS'(1);
      end
      if (cmd.kid_rd) v_ff <= slot_q;
      if (cmd.row_hit) row_ff <= v_ff - ROW_W'(1);
      if (cmd.insert) row_ff <= count_ff;
      if (cmd.row_miss) begin
         row_ff  <= ROW_W'(KERNEL_LIMIT);
         fail_ff <= 1'b1;
      end
      if (cmd.div_start) begin
         rem_ff  <= diff;
         dvs_ff  <= {w_eff, {BKT_W{1'b0}}};
         q_ff    <= '0;
         dcnt_ff <= DCNT_W'(BKT_W);
      end
      if (cmd.div_step) begin
         if (div_ge) rem_ff <= rem_ff - dvs_ff[63:0];
         dvs_ff  <= dvs_ff >> 1;
         q_ff    <= {q_ff[BKT_W-1:0], div_ge};
         dcnt_ff <= dcnt_ff - DCNT_W'(1);
      end
      if (cmd.rsp_load) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// ===== rtl/core/trace_record_time_bucket_aggregator.sv =====
// ---------------------------------------------------------------------------
// trace_record_time_bucket_aggregator
// Aggregates trace beats into per-SM heat counts and per-kernel bucket and
// total times, with a hashed kernel table and readback of every store.
// ---------------------------------------------------------------------------
// One beat is in flight at a time, from acceptance to result load. Beat time is set by the
// bit-per-cycle bucket divider and the probe walk, which reads the slot RAM and then the
// kernel id RAM. After reset a clearing pass zeroes the stores; no beat is taken during it.
// ---------------------------------------------------------------------------
module trace_record_time_bucket_aggregator
   import tba_pkg::*;
#(
   parameter int SM_COUNT     = 128,
   parameter int BUCKET_COUNT = 256,
   parameter int KERNEL_LIMIT = 64,
   parameter int HASH_BITS    = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [63:0] csr_data
);
   tba_cmd_type  cmd;
   tba_stat_type stat;

   // Configuration writes are always taken; indexes beyond the two registers
   // are accepted and ignored.
   assign csr_ready = 1'b1;

   // The controller sequences each beat; the datapath holds all storage and
   // the result register, so a finished result can wait while the next
   // beat is taken.
   tba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tba_dpath #(
      .SM_COUNT     (SM_COUNT),
      .BUCKET_COUNT (BUCKET_COUNT),
      .KERNEL_LIMIT (KERNEL_LIMIT),
      .HASH_BITS    (HASH_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Trace aggregator testbench
// Drives kernel registrations, records, drops and reads into the aggregator,
// predicts every response with a behavioural model of the stores and checks
// each response beat against it, under random idling on both channels.
// ---------------------------------------------------------------------------

// Behavioural model of the aggregator plus the queue of predicted responses.
class tba_scoreboard;
   localparam int SMS     = 128;
   localparam int BUCKETS = 256;
   localparam int KLIMIT  = 64;
   localparam int SLOTS   = 256;

   logic [63:0] origin;
   logic [63:0] width;
   logic [6:0]  slot_row [SLOTS];
   logic [31:0] row_id   [KLIMIT];
   int          rows_used;
   logic [31:0] heat     [int];
   logic [63:0] kbucket  [int];
   logic [63:0] ktotal   [KLIMIT+1];
   logic [63:0] records;
   logic [63:0] drops;
   tba_pkg::rsp_type pending[$];
   int          mismatches;

   function new();
      origin = 64'd0;
      width = 64'd1;
      foreach (slot_row[i]) slot_row[i] = '0;
      foreach (ktotal[i]) ktotal[i] = '0;
      rows_used = 0;
      records = '0;
      drops = '0;
      mismatches = 0;
   endfunction

   function void set_register(logic [7:0] idx, logic [63:0] val);
      if (idx == tba_pkg::CFG_START_TIME) origin = val;
      else if (idx == tba_pkg::CFG_BUCKET_WIDTH) width = val;
   endfunction

   function logic [31:0] murmur_mix(logic [31:0] x);
      x = x ^ (x >> 16);
      x = x * 32'h85ebca6b;
      x = x ^ (x >> 13);
      x = x * 32'hc2b2ae35;
      x = x ^ (x >> 16);
      return x;
   endfunction

   // Returns the row of id, -1 when absent, -2 when it could not be entered.
   function int lookup_row(logic [31:0] id, bit add);
      int pos;
      pos = int'(murmur_mix(id) & 32'(SLOTS - 1));
      for (int n = 0; n < SLOTS; n++) begin
         if (slot_row[pos] == 0) begin
            if (!add) return -1;
            if (rows_used >= KLIMIT) return -2;
            slot_row[pos] = 7'(rows_used + 1);
            row_id[rows_used] = id;
            rows_used++;
            return rows_used - 1;
         end
         if (slot_row[pos] <= KLIMIT && row_id[slot_row[pos]-1] == id)
            return int'(slot_row[pos]) - 1;
         pos = (pos + 1) % SLOTS;
      end
      return add ? -2 : -1;
   endfunction

   function void note_request(tba_pkg::req_type q);
      tba_pkg::rsp_type r;
      logic [63:0] w, b, dur;
      int rw, key;
      r.read_value = '0;
      r.status = tba_pkg::ST_OK;
      case (q.action)
         tba_pkg::ACT_REGISTER: begin
            rw = lookup_row(q.kernel_id, 1);
            if (rw < 0) r.status = tba_pkg::ST_FULL;
            else r.read_value = 64'(rw);
         end
         tba_pkg::ACT_RECORD: begin
            w = (width == 0) ? 64'd1 : width;
            b = (q.time_start < origin) ? 64'd0 : (q.time_start - origin) / w;
            if (b >= BUCKETS) b = 64'(BUCKETS - 1);
            dur = (q.time_end >= q.time_start) ? q.time_end - q.time_start : 64'd0;
            rw = lookup_row(q.kernel_id, 0);
            if (rw < 0) begin
               rw = KLIMIT;
               r.status = tba_pkg::ST_UNKNOWN;
            end
            if (q.sm_id < SMS) begin
               key = int'(q.sm_id) * BUCKETS + int'(b);
               heat[key] = (heat.exists(key) ? heat[key] : 32'd0) + 32'd1;
            end else begin
               r.status = tba_pkg::ST_SM_RANGE;
            end
            key = rw * BUCKETS + int'(b);
            kbucket[key] = (kbucket.exists(key) ? kbucket[key] : 64'd0) + dur;
            ktotal[rw] += dur;
            records++;
            r.read_value = 64'(rw);
         end
         tba_pkg::ACT_DROP: begin
            drops += q.drop_amount;
            r.read_value = drops;
         end
         tba_pkg::ACT_RD_HEAT: begin
            key = int'(q.read_row) * BUCKETS + int'(q.read_column);
            if (q.read_row < SMS && q.read_column < BUCKETS)
               r.read_value = heat.exists(key) ? 64'(heat[key]) : 64'd0;
            else r.status = tba_pkg::ST_INDEX;
         end
         tba_pkg::ACT_RD_KBKT: begin
            key = int'(q.read_row) * BUCKETS + int'(q.read_column);
            if (q.read_row <= KLIMIT && q.read_column < BUCKETS)
               r.read_value = kbucket.exists(key) ? kbucket[key] : 64'd0;
            else r.status = tba_pkg::ST_INDEX;
         end
         tba_pkg::ACT_RD_KTOT: begin
            if (q.read_row <= KLIMIT) r.read_value = ktotal[q.read_row];
            else r.status = tba_pkg::ST_INDEX;
         end
         tba_pkg::ACT_RD_KID: begin
            if (q.read_row < rows_used) r.read_value = 64'(row_id[q.read_row]);
            else r.status = tba_pkg::ST_INDEX;
         end
         default: begin
            if (q.read_column == tba_pkg::CNT_KERNELS) r.read_value = 64'(rows_used);
            else if (q.read_column == tba_pkg::CNT_RECORDS) r.read_value = records;
            else if (q.read_column == tba_pkg::CNT_DROPS) r.read_value = drops;
            else r.status = tba_pkg::ST_INDEX;
         end
      endcase
      pending.push_back(r);
   endfunction

   function void check_response(tba_pkg::rsp_type got);
      tba_pkg::rsp_type exp;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected response beat: value %h status %0d",
                     got.read_value, got.status);
         return;
      end
      exp = pending.pop_front();
      if (got.read_value !== exp.read_value || got.status !== exp.status) begin
         mismatches++;
         if (mismatches <= 10)
            $display("response mismatch: expected value %h status %0d, got %h %0d",
                     exp.read_value, exp.status, got.read_value, got.status);
      end
   endfunction
endclass

module testbench;
   import tba_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [63:0] csr_data;

   // Idle percentages for the sender and the receiver in the current phase.
   int send_idle;
   int recv_idle;
   int cycles;
   tba_scoreboard board;
   logic [31:0] known_ids [$];

   trace_record_time_bucket_aggregator u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // The receiver samples responses at the edge and decides its next ready
   // level in the same step, so each edge sees one assignment at most.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) board.check_response(rsp_data);
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // The watchdog ends the run if the block stops making progress.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Valid is left high at the accepting edge; the next idle cycle, the next
   // beat or a drain sets it, so no edge sees two assignments to it.
   task automatic send_beat(req_type q);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(q);
   endtask

   // Waits until every predicted response has arrived, then lets the block
   // finish any trailing work.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_register(logic [7:0] idx, logic [63:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_register(idx, val);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type blank_beat(logic [2:0] act);
      req_type q;
      q = '0;
      q.action = act;
      return q;
   endfunction

   function automatic logic [63:0] wide_random();
      return {$urandom(), $urandom()};
   endfunction

   // Random beat, weighted towards registrations and records of known ids
   // so that the stores fill up and reads land on live cells.
   function automatic req_type random_beat();
      req_type q;
      int pick;
      q = '0;
      q.kernel_id   = $urandom();
      q.sm_id       = ($urandom_range(9) == 0) ? 10'($urandom_range(1023))
                                               : 10'($urandom_range(127));
      q.time_start  = ($urandom_range(3) == 0) ? wide_random()
                                               : 64'($urandom_range(4000));
      q.time_end    = ($urandom_range(4) == 0) ? wide_random()
                                               : q.time_start + 64'($urandom_range(500));
      q.drop_amount = ($urandom_range(3) == 0) ? wide_random()
                                               : 64'($urandom_range(50));
      q.read_row    = ($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(64));
      q.read_column = ($urandom_range(7) == 0) ? 10'($urandom_range(1023))
                                               : 10'($urandom_range(255));
      if (known_ids.size() != 0 && $urandom_range(3) != 0)
         q.kernel_id = known_ids[$urandom_range(known_ids.size() - 1)];
      pick = $urandom_range(99);
      if (pick < 15) q.action = ACT_REGISTER;
      else if (pick < 55) q.action = ACT_RECORD;
      else if (pick < 60) q.action = ACT_DROP;
      else if (pick < 93) q.action = ACT_RD_HEAT + 3'($urandom_range(3));
      else begin
         q.action = ACT_RD_CNT;
         q.read_column = ($urandom_range(3) == 0) ? 10'($urandom_range(1023))
                                                  : 10'($urandom_range(2));
      end
      if (q.action == ACT_REGISTER && known_ids.size() < 80) known_ids.push_back(q.kernel_id);
      return q;
   endfunction

   initial begin
      req_type q;
      board = new();
      cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      send_idle = 0;
      recv_idle = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed beats: extremes, every action, and the SM range, unknown kernel and index cases.
      write_register(CFG_START_TIME, 64'd1000);
      write_register(CFG_BUCKET_WIDTH, 64'd10);
      q = blank_beat(ACT_REGISTER); q.kernel_id = 32'hFFFF_FFFF; send_beat(q);
      q = blank_beat(ACT_REGISTER); q.kernel_id = 32'h0;         send_beat(q);
      q = blank_beat(ACT_REGISTER); q.kernel_id = 32'hFFFF_FFFF; send_beat(q);
      known_ids.push_back(32'hFFFF_FFFF);
      known_ids.push_back(32'h0);
      // Start before the origin, with an end before the start.
      q = blank_beat(ACT_RECORD); q.kernel_id = 32'hFFFF_FFFF; q.sm_id = 10'd0;
      q.time_start = 64'd5; q.time_end = 64'd2; send_beat(q);
      // Late start clamped to the last bucket, largest times.
      q = blank_beat(ACT_RECORD); q.kernel_id = 32'h0; q.sm_id = 10'd127;
      q.time_start = 64'hFFFF_FFFF_FFFF_FFF0; q.time_end = '1; send_beat(q);
      // Unknown kernel, then unknown kernel with the SM out of range.
      q = blank_beat(ACT_RECORD); q.kernel_id = 32'h1234_5678; q.sm_id = 10'd3;
      q.time_start = 64'd1055; q.time_end = 64'd1100; send_beat(q);
      q = blank_beat(ACT_RECORD); q.kernel_id = 32'h1234_5678; q.sm_id = 10'h3FF;
      q.time_start = 64'd1055; q.time_end = 64'd1100; send_beat(q);
      q = blank_beat(ACT_DROP); q.drop_amount = '1; send_beat(q);
      q = blank_beat(ACT_DROP); q.drop_amount = 64'd2; send_beat(q);
      q = blank_beat(ACT_RD_HEAT); q.read_row = 8'd127; q.read_column = 10'd255; send_beat(q);
      q = blank_beat(ACT_RD_HEAT); q.read_row = 8'd255; q.read_column = 10'd0; send_beat(q);
      q = blank_beat(ACT_RD_HEAT); q.read_column = 10'h3FF; send_beat(q);
      q = blank_beat(ACT_RD_KBKT); q.read_row = 8'd64; q.read_column = 10'd5; send_beat(q);
      q = blank_beat(ACT_RD_KBKT); q.read_row = 8'd65; send_beat(q);
      q = blank_beat(ACT_RD_KTOT); q.read_row = 8'd64; send_beat(q);
      q = blank_beat(ACT_RD_KTOT); q.read_row = 8'd255; send_beat(q);
      q = blank_beat(ACT_RD_KID); q.read_row = 8'd1; send_beat(q);
      q = blank_beat(ACT_RD_KID); q.read_row = 8'd2; send_beat(q);
      for (int c = 0; c < 4; c++) begin
         q = blank_beat(ACT_RD_CNT); q.read_column = (c == 3) ? 10'h3FF : 10'(c); send_beat(q);
      end
      drain();

      // Random phases; the registers move between extremes at each boundary,
      // and the bucket width of zero is tried once.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 24 : (phase == 1) ? 83 : 0;
         recv_idle = (phase == 0) ? 83 : (phase == 1) ? 24 : 0;
         write_register(CFG_START_TIME, (phase == 1) ? '1 : 64'($urandom_range(2000)));
         write_register(CFG_BUCKET_WIDTH, (phase == 0) ? 64'd0 :
                        (phase == 1) ? '1 : 64'($urandom_range(1, 40)));
         for (int n = 0; n < 183; n++) begin
            send_beat(random_beat());
            if (phase == 2 && n == 100) drain();
         end
      end

      // Fill the kernel table past its limit so that the full status shows.
      for (int n = 0; n < 80; n++) begin
         q = blank_beat(ACT_REGISTER); q.kernel_id = $urandom(); send_beat(q);
      end
      q = blank_beat(ACT_RD_CNT); q.read_column = CNT_KERNELS; send_beat(q);

      drain();
      if (board.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
